FILE: design/sle_pkg.sv
// Shared types, constants and lookup functions for the scan code line editor.
// No dependencies; imported by every module of the block but sle_ram.
package sle_pkg;

  localparam int LineDepth = 128;
  localparam int LenW      = $clog2(LineDepth);
  localparam int CharW     = 7;
  localparam int NumWords  = 3;

  localparam logic [7:0] CodePrefix    = 8'hE0;
  localparam logic [7:0] CodeEnter     = 8'h1C;
  localparam logic [7:0] CodeBackspace = 8'h0E;

  // Command word indexes inside the match vector
  localparam int WordHelp    = 0;
  localparam int WordClear   = 1;
  localparam int WordVersion = 2;

  localparam int LenHelp    = 4;
  localparam int LenClear   = 5;
  localparam int LenVersion = 7;

  typedef enum logic [1:0] {
    EV_ECHO  = 2'd0,
    EV_ERASE = 2'd1,
    EV_LINE  = 2'd2
  } event_kind_e;

  typedef enum logic [2:0] {
    CMD_EMPTY   = 3'd0,
    CMD_HELP    = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_VERSION = 3'd3,
    CMD_UNKNOWN = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    KC_NONE,
    KC_PREFIX,
    KC_BREAK,
    KC_ENTER,
    KC_BKSP,
    KC_CHAR
  } key_class_e;

  typedef logic [NumWords-1:0] match_t;

  typedef struct packed {
    key_class_e             kclass;
    logic [CharW-1:0]       ascii;
  } key_t;

  typedef struct packed {
    event_kind_e            kind;
    logic [CharW-1:0]       ch;
    cmd_e                   cmd;
  } result_t;

  // One line entry: the character and the prefix match flags up to it
  typedef struct packed {
    logic [CharW-1:0]       ch;
    match_t                 mbits;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  // Set-1 make code to ASCII, zero where no character is produced
  function automatic logic [CharW-1:0] key_map(input logic [7:0] code);
    logic [CharW-1:0] c;
    case (code)
      8'h02: c = 7'h31;
      8'h03: c = 7'h32;
      8'h04: c = 7'h33;
      8'h05: c = 7'h34;
      8'h06: c = 7'h35;
      8'h07: c = 7'h36;
      8'h08: c = 7'h37;
      8'h09: c = 7'h38;
      8'h0A: c = 7'h39;
      8'h0B: c = 7'h30;
      8'h0C: c = 7'h2D;
      8'h0D: c = 7'h3D;
      8'h10: c = 7'h71;
      8'h11: c = 7'h77;
      8'h12: c = 7'h65;
      8'h13: c = 7'h72;
      8'h14: c = 7'h74;
      8'h15: c = 7'h79;
      8'h16: c = 7'h75;
      8'h17: c = 7'h69;
      8'h18: c = 7'h6F;
      8'h19: c = 7'h70;
      8'h1E: c = 7'h61;
      8'h1F: c = 7'h73;
      8'h20: c = 7'h64;
      8'h21: c = 7'h66;
      8'h22: c = 7'h67;
      8'h23: c = 7'h68;
      8'h24: c = 7'h6A;
      8'h25: c = 7'h6B;
      8'h26: c = 7'h6C;
      8'h2C: c = 7'h7A;
      8'h2D: c = 7'h78;
      8'h2E: c = 7'h63;
      8'h2F: c = 7'h76;
      8'h30: c = 7'h62;
      8'h31: c = 7'h6E;
      8'h32: c = 7'h6D;
      8'h39: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Character of a command word at a position, zero past its end
  function automatic logic [CharW-1:0] word_char(input int w, input logic [2:0] p);
    logic [CharW-1:0] c;
    c = '0;
    case (w)
      WordHelp: begin
        case (p)
          3'd0: c = 7'h68;
          3'd1: c = 7'h65;
          3'd2: c = 7'h6C;
          3'd3: c = 7'h70;
          default: c = '0;
        endcase
      end
      WordClear: begin
        case (p)
          3'd0: c = 7'h63;
          3'd1: c = 7'h6C;
          3'd2: c = 7'h65;
          3'd3: c = 7'h61;
          3'd4: c = 7'h72;
          default: c = '0;
        endcase
      end
      WordVersion: begin
        case (p)
          3'd0: c = 7'h76;
          3'd1: c = 7'h65;
          3'd2: c = 7'h72;
          3'd3: c = 7'h73;
          3'd4: c = 7'h69;
          3'd5: c = 7'h6F;
          3'd6: c = 7'h6E;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic int word_len(input int w);
    int n;
    case (w)
      WordHelp:    n = LenHelp;
      WordClear:   n = LenClear;
      WordVersion: n = LenVersion;
      default:     n = 0;
    endcase
    return n;
  endfunction

endpackage

FILE: design/sle_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sle_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: design/sle_decode.sv
// Scan byte classifier: prefix, break, enter, backspace, printable or none.
// Depends on sle_pkg.
module sle_decode
  import sle_pkg::*;
(
  input  logic [7:0] scan_byte_i,
  output key_t       key_o
);

  logic [CharW-1:0] ascii;

  assign ascii = key_map(scan_byte_i);

  always_comb begin
    key_o.ascii = ascii;
    if (scan_byte_i == CodePrefix) begin
      key_o.kclass = KC_PREFIX;
    end else if (scan_byte_i[7]) begin
      key_o.kclass = KC_BREAK;
    end else if (scan_byte_i == CodeEnter) begin
      key_o.kclass = KC_ENTER;
    end else if (scan_byte_i == CodeBackspace) begin
      key_o.kclass = KC_BKSP;
    end else if (ascii != '0) begin
      key_o.kclass = KC_CHAR;
    end else begin
      key_o.kclass = KC_NONE;
    end
  end

endmodule

FILE: design/sle_obuf.sv
// Two-entry output buffer (head register plus skid register).
// Depends on sle_pkg.
module sle_obuf
  import sle_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    head_valid_q, head_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t head_q, head_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = head_valid_q & ready_i;
  assign ready_o = ~skid_valid_q;
  assign valid_o = head_valid_q;
  assign data_o  = head_q;

  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else if (push_i) begin
        head_d = data_i;
      end else begin
        head_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!head_valid_q) begin
        head_d       = data_i;
        head_valid_d = 1'b1;
      end else begin
        skid_d       = data_i;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

endmodule

FILE: design/scancode_line_editor.sv
// Scan code line editor, top level. Depends on sle_pkg, sle_decode, sle_ram, sle_obuf.
// A result is registered in the output buffer and shown from its head register.
// Throughput: one scan byte per cycle while the buffer has room; the line RAM read on
// backspace is forwarded straight into the next cycle's update, so nothing waits on it.
// Reset clears the prefix flag, the line length and the output buffer; the line RAM
// is not cleared, since only entries below the line length are ever read.
module scancode_line_editor
  import sle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       scan_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       event_kind_o,
  output logic [CharW-1:0] echo_char_o,
  output logic [2:0]       command_code_o
);

  // Each RAM entry holds a character and, per command word, a flag saying the
  // line up to and including this entry equals that word's prefix. The flags of
  // the last stored entry live in top_q, so enter classifies the line without a RAM read.

  logic            accept;
  key_t            key;

  logic            pend_q, pend_d;        // extended prefix armed
  logic [LenW-1:0] len_q, len_d;          // stored character count
  match_t          top_q, top_d;          // match flags of the line as it stands
  logic            rd_pend_q, rd_pend_d;  // RAM read data carries the top flags

  logic            ram_we, ram_re;
  logic [LenW-1:0] ram_waddr, ram_raddr;
  entry_t          ram_wdata, ram_rdata;

  match_t          top_eff;
  match_t          new_bits;
  cmd_e            line_cmd;

  logic            push;
  result_t         res;
  result_t         head;
  logic            buf_ready;

  assign in_ready_o = buf_ready;
  assign accept     = in_valid_i & in_ready_o;

  sle_decode u_decode (
    .scan_byte_i (scan_byte_i),
    .key_o       (key)
  );

  sle_ram #(
    .Width (EntryW),
    .Depth (LineDepth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Forward the flags fetched by a backspace in the previous cycle
  assign top_eff = rd_pend_q ? ram_rdata.mbits : top_q;

  // Flags for appending key.ascii at position len_q
  always_comb begin
    for (int w = 0; w < NumWords; w++) begin
      new_bits[w] = top_eff[w] & (len_q < LenW'(word_len(w)))
                    & (key.ascii == word_char(w, len_q[2:0]));
    end
  end

  // Whole-line compare: length equals the word's and every prefix flag held
  always_comb begin
    if (len_q == '0) begin
      line_cmd = CMD_EMPTY;
    end else if ((len_q == LenW'(LenHelp)) && top_eff[WordHelp]) begin
      line_cmd = CMD_HELP;
    end else if ((len_q == LenW'(LenClear)) && top_eff[WordClear]) begin
      line_cmd = CMD_CLEAR;
    end else if ((len_q == LenW'(LenVersion)) && top_eff[WordVersion]) begin
      line_cmd = CMD_VERSION;
    end else begin
      line_cmd = CMD_UNKNOWN;
    end
  end

  always_comb begin
    pend_d    = pend_q;
    len_d     = len_q;
    top_d     = top_eff;
    rd_pend_d = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = len_q;
    ram_wdata = '{ch: key.ascii, mbits: new_bits};
    ram_re    = 1'b0;
    ram_raddr = len_q - LenW'(2);
    push      = 1'b0;
    res       = '{kind: EV_ECHO, ch: '0, cmd: CMD_EMPTY};

    if (accept) begin
      if (key.kclass == KC_PREFIX) begin
        pend_d = 1'b1;
      end else if (key.kclass == KC_BREAK) begin
        pend_d = 1'b0;
      end else if (pend_q) begin
        // swallow the byte after the prefix
        pend_d = 1'b0;
      end else begin
        case (key.kclass)
          KC_ENTER: begin
            len_d = '0;
            top_d = '1;
            push  = 1'b1;
            res   = '{kind: EV_LINE, ch: '0, cmd: line_cmd};
          end
          KC_BKSP: begin
            if (len_q != '0) begin
              len_d = len_q - LenW'(1);
              push  = 1'b1;
              res   = '{kind: EV_ERASE, ch: '0, cmd: CMD_EMPTY};
              if (len_q == LenW'(1)) begin
                top_d = '1;
              end else begin
                // fetch the flags of the new last entry
                ram_re    = 1'b1;
                rd_pend_d = 1'b1;
              end
            end
          end
          KC_CHAR: begin
            if (len_q < LenW'(LineDepth - 1)) begin
              ram_we = 1'b1;
              len_d  = len_q + LenW'(1);
              top_d  = new_bits;
              push   = 1'b1;
              res    = '{kind: EV_ECHO, ch: key.ascii, cmd: CMD_EMPTY};
            end
          end
          default: begin
            // unmapped make code: drop
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      len_q     <= '0;
      top_q     <= '1;
      rd_pend_q <= 1'b0;
    end else begin
      pend_q    <= pend_d;
      len_q     <= len_d;
      top_q     <= top_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  sle_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .ready_o (buf_ready),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (head)
  );

  assign event_kind_o   = head.kind;
  assign echo_char_o    = head.ch;
  assign command_code_o = head.cmd;

endmodule

FILE: verif/sle_checker.sv
// Scoreboard for the scan code line editor: watches both channels, predicts each result.
// Depends on sle_pkg for widths, codes and the result enums.
module line_edit_checker
  import sle_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic [7:0]       scan_byte_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [1:0]       event_kind_i,
  input  logic [CharW-1:0] echo_char_i,
  input  logic [2:0]       command_code_i,
  output int               mismatch_count_o,
  output int               pending_o
);

  typedef struct packed {
    event_kind_e      kind;
    logic [CharW-1:0] ch;
    cmd_e             cmd;
  } line_event_t;

  line_event_t      events_due[$];
  logic             prefix_armed;
  int               line_len;
  logic [CharW-1:0] line_chars [LineDepth];

  function automatic logic [CharW-1:0] ascii_of(input logic [7:0] b);
    string digits = "1234567890-=";
    string upper  = "qwertyuiop";
    string home   = "asdfghjkl";
    string lower  = "zxcvbnm";
    byte   c;
    c = 8'h00;
    if (b >= 8'h02 && b <= 8'h0D) c = digits[int'(b) - 8'h02];
    else if (b >= 8'h10 && b <= 8'h19) c = upper[int'(b) - 8'h10];
    else if (b >= 8'h1E && b <= 8'h26) c = home[int'(b) - 8'h1E];
    else if (b >= 8'h2C && b <= 8'h32) c = lower[int'(b) - 8'h2C];
    else if (b == 8'h39) c = 8'h20;  // space bar
    return c[CharW-1:0];
  endfunction

  function automatic bit line_equals(input string w);
    byte c;
    if (line_len != w.len()) return 1'b0;
    for (int i = 0; i < line_len; i++) begin
      c = w[i];
      if (line_chars[i] != c[CharW-1:0]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic cmd_e classify_line();
    if (line_len == 0) return CMD_EMPTY;
    if (line_equals("help")) return CMD_HELP;
    if (line_equals("clear")) return CMD_CLEAR;
    if (line_equals("version")) return CMD_VERSION;
    return CMD_UNKNOWN;
  endfunction

  function automatic void take_scan_byte(input logic [7:0] b);
    line_event_t      ev;
    logic [CharW-1:0] c;
    ev = '{kind: EV_ECHO, ch: '0, cmd: CMD_EMPTY};
    if (b == CodePrefix) begin
      prefix_armed = 1'b1;
    end else if (b[7]) begin
      prefix_armed = 1'b0;
    end else if (prefix_armed) begin
      // swallow the byte after a prefix
      prefix_armed = 1'b0;
    end else if (b == CodeEnter) begin
      ev.kind = EV_LINE;
      ev.cmd  = classify_line();
      line_len = 0;
      events_due.push_back(ev);
    end else if (b == CodeBackspace) begin
      if (line_len > 0) begin
        line_len--;
        ev.kind = EV_ERASE;
        events_due.push_back(ev);
      end
    end else begin
      c = ascii_of(b);
      if (c != '0 && line_len < LineDepth - 1) begin
        line_chars[line_len] = c;
        line_len++;
        ev.ch = c;
        events_due.push_back(ev);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    line_event_t exp_ev;
    if (!rst_ni) begin
      events_due.delete();
      prefix_armed = 1'b0;
      line_len = 0;
      mismatch_count_o <= 0;
      pending_o <= 0;
    end else begin
      // results leave only after their word is taken, so compare before predicting
      if (out_valid_i && out_ready_i) begin
        if (events_due.size() == 0) begin
          if (mismatch_count_o < 10)
            $display("unexpected result: kind %0d char %02h cmd %0d",
                     event_kind_i, echo_char_i, command_code_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          exp_ev = events_due.pop_front();
          if (event_kind_i !== exp_ev.kind || echo_char_i !== exp_ev.ch ||
              command_code_i !== exp_ev.cmd) begin
            if (mismatch_count_o < 10)
              $display("result mismatch: expected kind %0d char %02h cmd %0d, got %0d %02h %0d",
                       exp_ev.kind, exp_ev.ch, exp_ev.cmd,
                       event_kind_i, echo_char_i, command_code_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) take_scan_byte(scan_byte_i);
      pending_o <= events_due.size();
    end
  end

endmodule

FILE: verif/testbench.sv
// Top of the scan code line editor bench: clock, reset, scan byte stimulus and verdict.
// Depends on sle_pkg, scancode_line_editor and line_edit_checker (sle_checker.sv).
module testbench;
  import sle_pkg::*;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [7:0]       scan_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [1:0]       event_kind_o;
  logic [CharW-1:0] echo_char_o;
  logic [2:0]       command_code_o;

  int mismatch_count;
  int results_pending;
  int words_sent;
  int send_idle_pct;
  int recv_idle_pct;

  // Set-1 make codes used to build lines; the break bit marks a key release
  localparam logic [7:0] KeyS     = 8'h1F;
  localparam logic [7:0] KeyX     = 8'h2D;
  localparam logic [7:0] BreakBit = 8'h80;

  scancode_line_editor i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .scan_byte_i    (scan_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .event_kind_o   (event_kind_o),
    .echo_char_o    (echo_char_o),
    .command_code_o (command_code_o)
  );

  line_edit_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .scan_byte_i      (scan_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .event_kind_i     (event_kind_o),
    .echo_char_i      (echo_char_o),
    .command_code_i   (command_code_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (results_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hold the result channel back at random; the rate changes per phase
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Give up well past the slowest legal run
  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  // Drive one scan word and hold it until the block takes it. Afterwards idle
  // now and then, so gaps land on every kind of word.
  task automatic send_word(input logic [7:0] b, input bit counted);
    in_valid_i  <= 1'b1;
    scan_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (counted) words_sent++;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // Release a key now and then, the way a real keyboard does
  task automatic press_key(input logic [7:0] b);
    send_word(b, 1'b1);
    if ($urandom_range(0, 99) < 20) send_word(b | BreakBit, 1'b1);
  endtask

  function automatic logic [7:0] command_key(input int w, input int i);
    logic [7:0] k;
    k = 8'h00;
    case (w)
      WordHelp: begin
        case (i)
          0: k = 8'h23;  // h
          1: k = 8'h12;  // e
          2: k = 8'h26;  // l
          default: k = 8'h19;  // p
        endcase
      end
      WordClear: begin
        case (i)
          0: k = 8'h2E;  // c
          1: k = 8'h26;  // l
          2: k = 8'h12;  // e
          3: k = 8'h1E;  // a
          default: k = 8'h13;  // r
        endcase
      end
      default: begin
        case (i)
          0: k = 8'h2F;  // v
          1: k = 8'h12;  // e
          2: k = 8'h13;  // r
          3: k = 8'h1F;  // s
          4: k = 8'h17;  // i
          5: k = 8'h18;  // o
          default: k = 8'h31;  // n
        endcase
      end
    endcase
    return k;
  endfunction

  // Type a command word, either exact or slightly off, and finish the line.
  // Off by one: last letter dropped, a letter too many, first letter wrong; or a stray key erased first.
  task automatic type_command();
    int w;
    int n;
    int variant;
    w = $urandom_range(WordHelp, WordVersion);
    n = (w == WordHelp) ? LenHelp : (w == WordClear) ? LenClear : LenVersion;
    variant = $urandom_range(0, 5);
    if (variant == 4) begin
      press_key(8'($urandom_range(8'h02, 8'h39)));
      send_word(CodeBackspace, 1'b1);
    end
    for (int i = 0; i < n; i++) begin
      if (!(variant == 1 && i == n - 1))
        press_key((variant == 2 && i == 0) ? KeyX : command_key(w, i));
    end
    if (variant == 3) press_key(KeyS);
    send_word(CodeEnter, 1'b1);
  endtask

  // Free typing with some erasing, ended by Enter
  task automatic type_line(input int max_len, input int erase_pct);
    int n;
    n = $urandom_range(0, max_len);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < erase_pct) send_word(CodeBackspace, 1'b1);
      else press_key(8'($urandom_range(8'h02, 8'h39)));
    end
    send_word(CodeEnter, 1'b1);
  endtask

  // Fill the line to near or past capacity, erase a little, refill, end it
  task automatic fill_line();
    int n;
    n = $urandom_range(LineDepth - 3, LineDepth + 4);
    for (int i = 0; i < n; i++)
      send_word((i % 11 == 10) ? 8'h39 : 8'($urandom_range(8'h10, 8'h19)), 1'b1);
    repeat (2) send_word(CodeBackspace, 1'b1);
    repeat (4) send_word(8'($urandom_range(8'h1E, 8'h26)), 1'b1);
    send_word(CodeEnter, 1'b1);
  endtask

  // Anything at all: breaks, prefixes, prefixed keys, unmapped codes
  task automatic send_noise();
    int n;
    n = $urandom_range(1, 5);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) send_word(CodePrefix, 1'b1);
      send_word(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int pick;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    scan_byte_i   = 8'h00;
    out_ready_i   = 1'b0;
    words_sent    = 0;
    send_idle_pct = 11;
    recv_idle_pct = 85;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening: erase and Enter on an empty line, unmapped and break
    // extremes, a doubled prefix swallowing Enter, edge characters of the map,
    // a prefixed letter and a prefixed backspace, then an exact command.
    send_word(CodeBackspace, 1'b1);
    send_word(CodeEnter, 1'b1);
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    send_word(BreakBit, 1'b1);
    send_word(CodePrefix, 1'b1);
    send_word(CodePrefix, 1'b1);
    send_word(CodeEnter, 1'b1);
    send_word(8'h39, 1'b1);
    send_word(8'h02, 1'b1);
    send_word(8'h0D, 1'b1);
    send_word(8'h3A, 1'b1);
    send_word(8'h7F, 1'b1);
    send_word(CodeBackspace, 1'b1);
    send_word(CodePrefix, 1'b1);
    send_word(8'h23, 1'b1);
    send_word(CodeEnter, 1'b1);
    send_word(CodePrefix, 1'b1);
    send_word(CodeBackspace, 1'b1);
    for (int i = 0; i < LenHelp; i++) send_word(command_key(WordHelp, i), 1'b1);
    send_word(CodeEnter, 1'b1);

    // Random part in three idling phases; each opens with a full-line run
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 85 : 0;
      recv_idle_pct = (phase == 0) ? 85 : (phase == 1) ? 11 : 0;
      fill_line();
      while (words_sent < 650 * (phase + 1)) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) type_command();
        else if (pick < 65) type_line(12, 15);
        else if (pick < 80) type_line(6, 55);
        else send_noise();
      end
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every expected result, then let the clock run on before the verdict
    do @(posedge clk_i); while (results_pending != 0);
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: scancode_line_editor.f
design/sle_pkg.sv
design/sle_ram.sv
design/sle_decode.sv
design/sle_obuf.sv
design/scancode_line_editor.sv
verif/sle_checker.sv
verif/testbench.sv
